// File: design/spq_pkg.sv
// Shared types, codes and widths for the sorted priority queue table.
package spq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int CMD_W   = 2;
	localparam int ID_W    = 16;
	localparam int PRIO_W  = 8;
	localparam int PAGES_W = 16;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [PAGES_W-1:0] pages;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    rd_en;
		logic    wr_en;
		logic    wr_new;
		logic    count_inc;
		logic    count_dec;
		logic    res_load;
		status_t res_status;
		logic    res_hit;
		logic    publish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             req_valid;
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             lt;
		logic             match;
		logic             out_free;
	} dp_stat_t;

endpackage

// File: design/spq_if.sv
// Request and response channel interfaces of the sorted priority queue table.
interface spq_req_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [ID_W-1:0]    doc_id;
	logic [PRIO_W-1:0]  priority_req;
	logic [PAGES_W-1:0] pages;

	modport source (output valid, cmd, doc_id, priority_req, pages, input ready);
	modport sink (input valid, cmd, doc_id, priority_req, pages, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic               found;
	logic [CNT_W-1:0]   ahead;
	logic [CNT_W-1:0]   occupancy;
	logic [PRIO_W-1:0]  head_priority;
	logic [PRIO_W-1:0]  hit_priority;
	logic [PAGES_W-1:0] hit_pages;

	modport source (output valid, status, found, ahead, occupancy, head_priority,
		hit_priority, hit_pages, input ready);
	modport sink (input valid, status, found, ahead, occupancy, head_priority,
		hit_priority, hit_pages, output ready);
endinterface

// File: design/spq_dp.sv
// Datapath: job memory, read register, count, head priority and response register.
module spq_dp #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	spq_req_if.sink                       req,
	spq_rsp_if.source                     rsp,
	input  spq_pkg::dp_cmd_t              ctl,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [$clog2(DEPTH+1)-1:0]    res_ahead,
	output spq_pkg::dp_stat_t             stat,
	output logic [$clog2(DEPTH+1)-1:0]    count
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	entry_t             rd_q;
	entry_t             new_q;
	entry_t             wr_data;
	logic [CMD_W-1:0]   cmd_q;
	logic [CW-1:0]      count_q;
	logic [PRIO_W-1:0]  head_q;

	status_t            res_status_q;
	logic               res_found_q;
	logic [CNT_W-1:0]   res_ahead_q;
	logic [PRIO_W-1:0]  res_prio_q;
	logic [PAGES_W-1:0] res_pages_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic               out_found_q;
	logic [CNT_W-1:0]   out_ahead_q;
	logic [CNT_W-1:0]   out_occ_q;
	logic [PRIO_W-1:0]  out_head_q;
	logic [PRIO_W-1:0]  out_prio_q;
	logic [PAGES_W-1:0] out_pages_q;

	assign wr_data = ctl.wr_new ? new_q : rd_q;

	// Job memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Request latch, head priority and staged result
	always_ff @(posedge clk) begin
		if (ctl.capture && req.valid) begin
			cmd_q        <= req.cmd;
			new_q.id     <= req.doc_id;
			new_q.prio   <= req.priority_req;
			new_q.pages  <= req.pages;
		end
		if (ctl.wr_en && (wr_addr == '0)) begin
			head_q <= wr_data.prio;
		end
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			res_found_q  <= ctl.res_hit;
			res_ahead_q  <= CNT_W'(res_ahead);
			res_prio_q   <= ctl.res_hit ? rd_q.prio : '0;
			res_pages_q  <= ctl.res_hit ? rd_q.pages : '0;
		end
		if (ctl.publish) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_ahead_q  <= res_ahead_q;
			out_occ_q    <= CNT_W'(count_q);
			out_head_q   <= (count_q != '0) ? head_q : '0;
			out_prio_q   <= res_prio_q;
			out_pages_q  <= res_pages_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready = ctl.capture;

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.found         = out_found_q;
	assign rsp.ahead         = out_ahead_q;
	assign rsp.occupancy     = out_occ_q;
	assign rsp.head_priority = out_head_q;
	assign rsp.hit_priority  = out_prio_q;
	assign rsp.hit_pages     = out_pages_q;

	assign stat.req_valid = req.valid;
	assign stat.cmd       = cmd_q;
	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.lt        = (rd_q.prio < new_q.prio);
	assign stat.match     = (rd_q.id == new_q.id);
	assign stat.out_free  = !out_valid_q || rsp.ready;

	assign count = count_q;

endmodule

// File: design/spq_ctrl.sv
// Controller: sequences the walk over the job memory for each request.
module spq_ctrl #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spq_pkg::dp_stat_t             stat,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	output spq_pkg::dp_cmd_t              ctl,
	output logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [$clog2(DEPTH)-1:0]      wr_addr,
	output logic [$clog2(DEPTH+1)-1:0]    res_ahead
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_CMP,
		S_INS_PUT,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] idx_inc, idx_dec, idx_dec2, cnt_dec;
	logic          at_tail;

	assign idx_inc  = idx_q + 1'b1;
	assign idx_dec  = idx_q - 1'b1;
	assign idx_dec2 = idx_q - CW'(2);
	assign cnt_dec  = count - 1'b1;
	assign at_tail  = (idx_inc == count);

	always_comb begin
		ctl            = '0;
		ctl.res_status = ST_OK;
		rd_addr        = '0;
		wr_addr        = '0;
		res_ahead      = '0;
		state_d        = state_q;
		idx_d          = idx_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.capture = 1'b1;
				if (stat.req_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							ctl.res_load   = 1'b1;
							ctl.res_status = ST_FULL;
							state_d        = S_FINISH;
						end else if (stat.empty) begin
							ctl.wr_en     = 1'b1;
							ctl.wr_new    = 1'b1;
							ctl.count_inc = 1'b1;
							ctl.res_load  = 1'b1;
							state_d       = S_FINISH;
						end else begin
							ctl.rd_en = 1'b1;
							rd_addr   = cnt_dec[AW-1:0];
							idx_d     = count;
							state_d   = S_INS_CMP;
						end
					end
					CMD_REMOVE, CMD_LOOKUP: begin
						if (stat.empty) begin
							ctl.res_load   = 1'b1;
							ctl.res_status = ST_EMPTY;
							state_d        = S_FINISH;
						end else begin
							ctl.rd_en = 1'b1;
							idx_d     = '0;
							state_d   = S_SCAN;
						end
					end
					default: begin
						ctl.res_load = 1'b1;
						state_d      = S_FINISH;
					end
				endcase
			end
			S_INS_CMP: begin
				if (stat.lt) begin
					ctl.wr_en = 1'b1;
					wr_addr   = idx_q[AW-1:0];
					idx_d     = idx_dec;
					if (idx_dec == '0) begin
						state_d = S_INS_PUT;
					end else begin
						ctl.rd_en = 1'b1;
						rd_addr   = idx_dec2[AW-1:0];
					end
				end else begin
					ctl.wr_en     = 1'b1;
					ctl.wr_new    = 1'b1;
					wr_addr       = idx_q[AW-1:0];
					ctl.count_inc = 1'b1;
					ctl.res_load  = 1'b1;
					res_ahead     = idx_q;
					state_d       = S_FINISH;
				end
			end
			S_INS_PUT: begin
				ctl.wr_en     = 1'b1;
				ctl.wr_new    = 1'b1;
				wr_addr       = idx_q[AW-1:0];
				ctl.count_inc = 1'b1;
				ctl.res_load  = 1'b1;
				res_ahead     = idx_q;
				state_d       = S_FINISH;
			end
			S_SCAN: begin
				if (stat.match) begin
					ctl.res_load = 1'b1;
					ctl.res_hit  = 1'b1;
					if (stat.cmd == CMD_LOOKUP) begin
						state_d = S_FINISH;
					end else if (at_tail) begin
						ctl.count_dec = 1'b1;
						state_d       = S_FINISH;
					end else begin
						ctl.rd_en = 1'b1;
						rd_addr   = idx_inc[AW-1:0];
						idx_d     = idx_inc;
						state_d   = S_SHIFT;
					end
				end else if (at_tail) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = ST_NOTFOUND;
					state_d        = S_FINISH;
				end else begin
					ctl.rd_en = 1'b1;
					rd_addr   = idx_inc[AW-1:0];
					idx_d     = idx_inc;
				end
			end
			S_SHIFT: begin
				ctl.wr_en = 1'b1;
				wr_addr   = idx_dec[AW-1:0];
				if (at_tail) begin
					ctl.count_dec = 1'b1;
					state_d       = S_FINISH;
				end else begin
					ctl.rd_en = 1'b1;
					rd_addr   = idx_inc[AW-1:0];
					idx_d     = idx_inc;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// File: design/sorted_priority_queue_table.sv
// Top level of the sorted priority queue table.
// A table of up to DEPTH jobs (id, priority, page count) held in descending
// priority order in a job memory with one write port and one registered read
// port, one write and one read per cycle. One request is worked at a time. An
// insert walks from the tail toward the head, moving each lower-priority entry
// up one slot as it goes. A remove or lookup walks from the head, one entry a
// cycle; a remove then keeps walking to the tail, moving each later entry down
// one slot. A new request is taken as soon as the block returns to idle, even
// while the previous response still waits in the output register; the next
// response is held until that one is taken. The memory needs no clearing after
// reset: only slots below the count are ever read.
module sorted_priority_queue_table #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	dp_cmd_t       ctl;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] res_ahead;
	logic [CW-1:0] count;

	// Sequencer: decodes the request and steps the walk
	spq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.count     (count),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.res_ahead (res_ahead)
	);

	// Storage, compare and response register
	spq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.res_ahead (res_ahead),
		.stat      (stat),
		.count     (count)
	);

	// The count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("job count exceeds table size");

	// The count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count == $past(count)) || (count == $past(count) + 1'b1) ||
			(count + 1'b1 == $past(count)))
		else $error("job count jumped");

	// A hit is always a successful remove or lookup with no position
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> (rsp.status == ST_OK) && (rsp.ahead == '0))
		else $error("hit reported with bad status or position");

	// A taken request blocks the next one until its walk is done
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while busy");

endmodule

// File: tb/sorted_priority_queue_table_test.sv
// Self-checking testbench of the sorted priority queue table: directed and random requests.
module sorted_priority_queue_table_test;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = DEPTH_DEFAULT;
	localparam int RAND_REQS  = 800;
	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN_WAIT = 40;
	localparam int MAX_SHOWN  = 10;
	localparam int GAP_PCT    = 23;
	// Requests accepted within this window see no idling on either side.
	localparam int QUIET_LO   = 350;
	localparam int QUIET_HI   = 470;

	// Code 3 is not part of cmd_t; the block must ignore it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [PAGES_W-1:0] pages;
	} job_req_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [CNT_W-1:0]   ahead;
		logic [CNT_W-1:0]   occupancy;
		logic [PRIO_W-1:0]  head_prio;
		logic [PRIO_W-1:0]  hit_prio;
		logic [PAGES_W-1:0] hit_pages;
	} job_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_table #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Requests waiting to be driven, and responses predicted for accepted requests.
	job_req_t pending_reqs[$];
	job_rsp_t expected_rsps[$];

	// Shadow of the job table, kept in priority order like the block's memory.
	logic [ID_W-1:0]    tbl_id[DEPTH];
	logic [PRIO_W-1:0]  tbl_prio[DEPTH];
	logic [PAGES_W-1:0] tbl_pages[DEPTH];
	int                 tbl_count = 0;

	int accepted_reqs = 0;
	int mismatches    = 0;
	int cycles        = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// Work out the response of one request and update the shadow table.
	task automatic apply_queue_op(input job_req_t r, output job_rsp_t e);
		int pos;
		int i;
		e = '0;
		e.status = ST_OK;
		case (r.cmd)
			CMD_INSERT: begin
				if (tbl_count >= DEPTH) begin
					e.status = ST_FULL;
				end else begin
					// Equal priorities stay ahead: stop at the first strictly lower one.
					pos = 0;
					while (pos < tbl_count && tbl_prio[pos] >= r.prio)
						pos++;
					for (i = tbl_count; i > pos; i--) begin
						tbl_id[i]    = tbl_id[i-1];
						tbl_prio[i]  = tbl_prio[i-1];
						tbl_pages[i] = tbl_pages[i-1];
					end
					tbl_id[pos]    = r.id;
					tbl_prio[pos]  = r.prio;
					tbl_pages[pos] = r.pages;
					tbl_count++;
					e.ahead = CNT_W'(pos);
				end
			end
			CMD_REMOVE, CMD_LOOKUP: begin
				if (tbl_count == 0) begin
					e.status = ST_EMPTY;
				end else begin
					// First match from the head wins when ids repeat.
					pos = 0;
					while (pos < tbl_count && tbl_id[pos] != r.id)
						pos++;
					if (pos >= tbl_count) begin
						e.status = ST_NOTFOUND;
					end else begin
						e.found     = 1'b1;
						e.hit_prio  = tbl_prio[pos];
						e.hit_pages = tbl_pages[pos];
						if (r.cmd == CMD_REMOVE) begin
							for (i = pos; i + 1 < tbl_count; i++) begin
								tbl_id[i]    = tbl_id[i+1];
								tbl_prio[i]  = tbl_prio[i+1];
								tbl_pages[i] = tbl_pages[i+1];
							end
							tbl_count--;
						end
					end
				end
			end
			default: begin
				// Unused code: table untouched, plain ok response.
			end
		endcase
		e.occupancy = CNT_W'(tbl_count);
		e.head_prio = (tbl_count != 0) ? tbl_prio[0] : '0;
	endtask

	// Random idle decision, switched off for one stretch of the run.
	function automatic bit take_gap();
		if (accepted_reqs >= QUIET_LO && accepted_reqs < QUIET_HI)
			return 1'b0;
		return $urandom_range(0, 99) < GAP_PCT;
	endfunction

	task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input logic [PAGES_W-1:0] pages);
		job_req_t r;
		r.cmd   = cmd;
		r.id    = id;
		r.prio  = prio;
		r.pages = pages;
		pending_reqs.push_back(r);
	endtask

	// Directed corner cases, then random bursts biased to fill, drain or mix.
	task automatic build_requests();
		logic [ID_W-1:0]   id_pool[8];
		logic [PRIO_W-1:0] prio_pool[4];
		logic [CMD_W-1:0]  cmd;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		mix_t mix;
		int made;
		int burst;
		int roll;
		int k;

		// Empty table: lookup, remove and the unused code.
		add_req(CMD_LOOKUP, 16'h1234, 8'h00, 16'h0000);
		add_req(CMD_REMOVE, 16'h1234, 8'h00, 16'h0000);
		add_req(CMD_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
		// Insert into an empty table, then at both priority extremes.
		add_req(CMD_INSERT, 16'h00A5, 8'h80, 16'h1111);
		add_req(CMD_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
		add_req(CMD_INSERT, 16'h0000, 8'h00, 16'h0000);
		// Same id and same priority: goes behind the earlier one.
		add_req(CMD_INSERT, 16'h00A5, 8'h80, 16'h2222);
		add_req(CMD_LOOKUP, 16'h00A5, 8'h00, 16'h0000);
		add_req(CMD_LOOKUP, 16'h5A5A, 8'h00, 16'h0000);
		add_req(CMD_REMOVE, 16'h5A5A, 8'h00, 16'h0000);
		// Fill up to the last slot, then one insert too many.
		for (k = 0; k < DEPTH - 4; k++)
			add_req(CMD_INSERT, ID_W'(16'h0100 + k), PRIO_W'($urandom_range(0, 255)),
				PAGES_W'($urandom));
		add_req(CMD_INSERT, 16'h7777, 8'hFF, 16'h7777);
		add_req(CMD_REMOVE, 16'h00A5, 8'h00, 16'h0000);
		add_req(CMD_LOOKUP, 16'h0000, 8'h00, 16'h0000);
		add_req(CMD_UNUSED, 16'h0000, 8'h00, 16'h0000);

		id_pool[0] = '0;
		id_pool[1] = '1;
		for (k = 2; k < 8; k++)
			id_pool[k] = ID_W'($urandom);
		prio_pool[0] = '0;
		prio_pool[1] = '1;
		prio_pool[2] = PRIO_W'($urandom);
		prio_pool[3] = PRIO_W'($urandom);

		made = 0;
		while (made < RAND_REQS) begin
			mix = mix_t'($urandom_range(0, 2));
			burst = $urandom_range(20, 60);
			for (k = 0; k < burst; k++) begin
				roll = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:  cmd = (roll < 75) ? CMD_INSERT : (roll < 90) ? CMD_REMOVE :
						(roll < 97) ? CMD_LOOKUP : CMD_UNUSED;
					MIX_DRAIN: cmd = (roll < 25) ? CMD_INSERT : (roll < 75) ? CMD_REMOVE :
						(roll < 97) ? CMD_LOOKUP : CMD_UNUSED;
					default:   cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE :
						(roll < 97) ? CMD_LOOKUP : CMD_UNUSED;
				endcase
				// Mostly pooled ids and often pooled priorities so hits, duplicates and ties are common.
				id = ($urandom_range(0, 99) < 75) ? id_pool[$urandom_range(0, 7)] :
					ID_W'($urandom);
				prio = ($urandom_range(0, 99) < 40) ? prio_pool[$urandom_range(0, 3)] :
					PRIO_W'($urandom);
				add_req(cmd, id, prio, PAGES_W'($urandom));
				made++;
			end
		end
	endtask

	// Driver: hold a request until accepted, predict it at acceptance, then advance.
	always @(posedge clk or negedge arst_n) begin
		job_req_t nxt;
		job_rsp_t want;
		if (!arst_n) begin
			req_ch.valid        <= 1'b0;
			req_ch.cmd          <= '0;
			req_ch.doc_id       <= '0;
			req_ch.priority_req <= '0;
			req_ch.pages        <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				nxt.cmd   = req_ch.cmd;
				nxt.id    = req_ch.doc_id;
				nxt.prio  = req_ch.priority_req;
				nxt.pages = req_ch.pages;
				apply_queue_op(nxt, want);
				expected_rsps.push_back(want);
				accepted_reqs <= accepted_reqs + 1;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// Hold the request and its fields until the block takes it.
			end else if (pending_reqs.size() != 0 && !take_gap()) begin
				nxt = pending_reqs.pop_front();
				req_ch.valid        <= 1'b1;
				req_ch.cmd          <= nxt.cmd;
				req_ch.doc_id       <= nxt.id;
				req_ch.priority_req <= nxt.prio;
				req_ch.pages        <= nxt.pages;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: stall the response side at random and check each response in order.
	always @(posedge clk or negedge arst_n) begin
		job_rsp_t got;
		job_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !take_gap();
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status    = status_t'(rsp_ch.status);
				got.found     = rsp_ch.found;
				got.ahead     = rsp_ch.ahead;
				got.occupancy = rsp_ch.occupancy;
				got.head_prio = rsp_ch.head_priority;
				got.hit_prio  = rsp_ch.hit_priority;
				got.hit_pages = rsp_ch.hit_pages;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: response with no request outstanding: st=%0d found=%0d",
							$realtime, got.status, got.found);
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN) begin
							$display("%0t: mismatch  st found ahead occ head hprio hpages", $realtime);
							$display("  expected  %0d %0d %0d %0d %0d %0d %0d", want.status,
								want.found, want.ahead, want.occupancy, want.head_prio,
								want.hit_prio, want.hit_pages);
							$display("  actual    %0d %0d %0d %0d %0d %0d %0d", got.status,
								got.found, got.ahead, got.occupancy, got.head_prio,
								got.hit_prio, got.hit_pages);
						end
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin : watchdog
		while (cycles < MAX_CYCLES)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		// Known values on every input before the first edge.
		req_ch.valid        = 1'b0;
		req_ch.cmd          = '0;
		req_ch.doc_id       = '0;
		req_ch.priority_req = '0;
		req_ch.pages        = '0;
		rsp_ch.ready        = 1'b0;
		build_requests();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every request is taken and every response has come back.
		while (pending_reqs.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		// Give a late extra response time to show up.
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
